FILE: rtl/core/tkc_pkg.sv
// ----------------------------------------------------------------------------
// tkc_pkg
// Shared types and constants of the Trivium keystream cipher: state layout,
// register indexes, controller states and the command bundle.
// ----------------------------------------------------------------------------
package tkc_pkg;

    localparam int LEN_A = 93;
    localparam int LEN_B = 84;
    localparam int LEN_C = 111;

    localparam int KEY_LOW_W  = 64;
    localparam int KEY_HIGH_W = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int BYTE_W     = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH  = 2'd3;

    // s1..s93 in a, s94..s177 in b, s178..s288 in c; bit k of each is
    // position k of that shift register
    typedef struct packed {
        logic [LEN_C-1:0] c;
        logic [LEN_B-1:0] b;
        logic [LEN_A-1:0] a;
    } state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WARM,
        ST_GEN
    } ctrl_state_t;

    typedef struct packed {
        logic load;       // load state from key and IV
        logic hold_byte;  // capture the request byte for later
        logic warm_many;  // advance by the wide round unit, no output
        logic warm_one;   // advance by one round, no output
        logic gen;        // advance by the wide unit and load the result
        logic use_held;   // take the byte from the hold register
    } cmd_t;

endpackage

FILE: rtl/core/trivium_keystream_cipher_top.sv
// ----------------------------------------------------------------------------
// trivium_keystream_cipher_top
// Trivium stream cipher, one byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   Write the key and IV through the cfg channel (index 0 key bits 0..63,
//   1 key bits 64..79, 2 IV bits 0..63, 3 IV bits 64..79) while idle.
//   Send bytes on s_tdata; s_tuser high on a request reloads key and IV
//   and runs the warm-up before that byte is handled.
//   Each result on m_tdata is the byte XOR BITS_PER_ITEM keystream bits,
//   the first bit at the MSB.
// Timing:
//   A plain request's result is registered as it is accepted and shows in the
//   next cycle; a new request is taken every cycle while m_tready is high or
//   the result register is empty; the wide round unit advances the state by
//   BITS_PER_ITEM rounds per cycle.
//   A restart request runs the warm-up, wide steps while they fit and single
//   rounds for the rest, then encrypts the held byte; s_tready is low meanwhile.
// Reset clears the state, key and IV to zero; until the first restart the
// keystream is zero. When m_tready is low the result register holds and
// s_tready drops once it is full.
// ----------------------------------------------------------------------------
module trivium_keystream_cipher_top #(
    parameter int WARMUP_ROUNDS = 1152,
    parameter int BITS_PER_ITEM = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tkc_pkg::BYTE_W-1:0]          s_tdata,   // [7:0] plain_byte
    input  logic                                s_tuser,   // [0] restart
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tkc_pkg::BYTE_W-1:0]          m_tdata,   // [7:0] cipher_byte
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tkc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tkc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tkc_pkg::*;

    cmd_t cmd;

    assign cfg_ready = 1'b1;

    tkc_ctrl #(
        .WARMUP_ROUNDS (WARMUP_ROUNDS),
        .BITS_PER_ITEM (BITS_PER_ITEM)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    tkc_datapath #(
        .BITS_PER_ITEM (BITS_PER_ITEM)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .plain_byte  (s_tdata),
        .cipher_byte (m_tdata)
    );

endmodule

FILE: rtl/core/tkc_round.sv
// ----------------------------------------------------------------------------
// tkc_round
// Unrolled Trivium update: ROUNDS parallel rounds of the 288-bit state.
// Up to 64 rounds draw only on bits of the present state, so all of them
// are computed side by side.
// ----------------------------------------------------------------------------
module tkc_round #(
    parameter int ROUNDS = 8
) (
    input  tkc_pkg::state_t    cur,
    output tkc_pkg::state_t    nxt,
    output logic [ROUNDS-1:0]  ks    // ks[j] is the bit of round j
);
    import tkc_pkg::*;

    logic [ROUNDS-1:0] fa;
    logic [ROUNDS-1:0] fb;
    logic [ROUNDS-1:0] fc;

    genvar j;
    genvar k;
    generate
        for (j = 0; j < ROUNDS; j++)
        begin : g_round
            logic t1;
            logic t2;
            logic t3;
            assign t1 = cur.a[65-j] ^ cur.a[92-j];
            assign t2 = cur.b[68-j] ^ cur.b[83-j];
            assign t3 = cur.c[65-j] ^ cur.c[110-j];
            assign ks[j] = t1 ^ t2 ^ t3;
            assign fa[j] = t3 ^ (cur.c[108-j] & cur.c[109-j]) ^ cur.a[68-j];
            assign fb[j] = t1 ^ (cur.a[90-j] & cur.a[91-j]) ^ cur.b[77-j];
            assign fc[j] = t2 ^ (cur.b[81-j] & cur.b[82-j]) ^ cur.c[86-j];
        end

        // shift by ROUNDS, the last round's bit ending up at position 0
        for (k = 0; k < LEN_A; k++)
        begin : g_sa
            if (k < ROUNDS)
            begin : g_new
                assign nxt.a[k] = fa[ROUNDS-1-k];
            end
            else
            begin : g_old
                assign nxt.a[k] = cur.a[k-ROUNDS];
            end
        end
        for (k = 0; k < LEN_B; k++)
        begin : g_sb
            if (k < ROUNDS)
            begin : g_new
                assign nxt.b[k] = fb[ROUNDS-1-k];
            end
            else
            begin : g_old
                assign nxt.b[k] = cur.b[k-ROUNDS];
            end
        end
        for (k = 0; k < LEN_C; k++)
        begin : g_sc
            if (k < ROUNDS)
            begin : g_new
                assign nxt.c[k] = fc[ROUNDS-1-k];
            end
            else
            begin : g_old
                assign nxt.c[k] = cur.c[k-ROUNDS];
            end
        end
    endgenerate

endmodule

FILE: rtl/core/tkc_datapath.sv
// ----------------------------------------------------------------------------
// tkc_datapath
// Key and IV registers, cipher state, held request byte and result register.
// The key and IV take cfg writes; all else acts only on controller commands.
// ----------------------------------------------------------------------------
module tkc_datapath #(
    parameter int BITS_PER_ITEM = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tkc_pkg::cmd_t                       cmd,
    input  logic                                cfg_write,
    input  logic [tkc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tkc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [tkc_pkg::BYTE_W-1:0]          plain_byte,
    output logic [tkc_pkg::BYTE_W-1:0]          cipher_byte
);
    import tkc_pkg::*;

    logic [KEY_LOW_W-1:0]  key_low_reg;
    logic [KEY_HIGH_W-1:0] key_high_reg;
    logic [KEY_LOW_W-1:0]  iv_low_reg;
    logic [KEY_HIGH_W-1:0] iv_high_reg;

    state_t st_reg;
    state_t st_next;
    state_t st_load;
    state_t st_many;
    state_t st_one;

    logic [BITS_PER_ITEM-1:0] ks_many;
    logic [0:0]               ks_one;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] out_reg;
    logic [BYTE_W-1:0] src_byte;
    logic [BYTE_W-1:0] cipher_next;

    tkc_round #(.ROUNDS(BITS_PER_ITEM)) u_round_many (
        .cur (st_reg),
        .nxt (st_many),
        .ks  (ks_many)
    );

    tkc_round #(.ROUNDS(1)) u_round_one (
        .cur (st_reg),
        .nxt (st_one),
        .ks  (ks_one)
    );

    // key in A, IV in B, three ones at the top of C
    always_comb
    begin
        st_load.a = {{(LEN_A - KEY_LOW_W - KEY_HIGH_W){1'b0}}, key_high_reg, key_low_reg};
        st_load.b = {{(LEN_B - KEY_LOW_W - KEY_HIGH_W){1'b0}}, iv_high_reg, iv_low_reg};
        st_load.c = {3'b111, {(LEN_C - 3){1'b0}}};
    end

    always_comb
    begin
        if (cmd.load)
            st_next = st_load;
        else if (cmd.warm_many || cmd.gen)
            st_next = st_many;
        else if (cmd.warm_one)
            st_next = st_one;
        else
            st_next = st_reg;
    end

    assign src_byte = cmd.use_held ? byte_reg : plain_byte;

    // first keystream bit lands on the highest bit of the word; bits above
    // the word width pass through
    genvar b;
    generate
        for (b = 0; b < BYTE_W; b++)
        begin : g_mix
            if (b < BITS_PER_ITEM)
            begin : g_ks
                assign cipher_next[b] = src_byte[b] ^ ks_many[BITS_PER_ITEM-1-b];
            end
            else
            begin : g_pass
                assign cipher_next[b] = src_byte[b];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            iv_low_reg   <= '0;
            iv_high_reg  <= '0;
            st_reg       <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                    CFG_KEY_HIGH: key_high_reg <= cfg_data[KEY_HIGH_W-1:0];
                    CFG_IV_LOW:   iv_low_reg   <= cfg_data;
                    CFG_IV_HIGH:  iv_high_reg  <= cfg_data[KEY_HIGH_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hold_byte)
            byte_reg <= plain_byte;
        if (cmd.gen)
            out_reg <= cipher_next;
    end

    assign cipher_byte = out_reg;

endmodule

FILE: rtl/core/tkc_ctrl.sv
// ----------------------------------------------------------------------------
// tkc_ctrl
// Sequencer of the cipher: takes requests, runs the warm-up count after a
// restart and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module tkc_ctrl #(
    parameter int WARMUP_ROUNDS = 1152,
    parameter int BITS_PER_ITEM = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    input  logic          s_tuser,
    output logic          s_tready,
    input  logic          m_tready,
    output logic          m_tvalid,
    output tkc_pkg::cmd_t cmd
);
    import tkc_pkg::*;

    localparam int CNT_W = $clog2(WARMUP_ROUNDS + 1);
    localparam logic [CNT_W-1:0] WARM_INIT = CNT_W'(WARMUP_ROUNDS);
    localparam logic [CNT_W-1:0] STEP      = CNT_W'(BITS_PER_ITEM);
    localparam logic [CNT_W-1:0] ONE       = CNT_W'(1);

    ctrl_state_t      state_reg;
    ctrl_state_t      state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = out_free;
                if (s_tvalid && out_free)
                begin
                    if (s_tuser)
                    begin
                        cmd.load      = 1'b1;
                        cmd.hold_byte = 1'b1;
                        cnt_next      = WARM_INIT;
                        state_next    = ST_WARM;
                    end
                    else
                    begin
                        cmd.gen = 1'b1;
                    end
                end
            end
            ST_WARM:
            begin
                // wide steps while they fit, single rounds for the rest
                if (cnt_reg >= STEP)
                begin
                    cmd.warm_many = 1'b1;
                    cnt_next      = cnt_reg - STEP;
                end
                else
                begin
                    cmd.warm_one = 1'b1;
                    cnt_next     = cnt_reg - ONE;
                end
                if (cnt_next == '0)
                    state_next = ST_GEN;
            end
            ST_GEN:
            begin
                if (out_free)
                begin
                    cmd.gen      = 1'b1;
                    cmd.use_held = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.gen)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_warm_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WARM |-> cnt_reg != '0)
        else $error("warm-up running with an empty count");

    a_restart_loads: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> state_reg == ST_WARM && cnt_reg == WARM_INIT)
        else $error("restart request did not start the warm-up");

    a_gen_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gen |=> out_valid_reg)
        else $error("result not presented after generation");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.warm_many, cmd.warm_one, cmd.gen}))
        else $error("conflicting state update commands");
`endif

endmodule

FILE: tb/sv/trivium_keystream_cipher_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trivium_keystream_cipher_top_tb
// Self-checking bench for the byte-wide Trivium cipher. A bit-level model of
// the three shift registers predicts every cipher byte. A short table covers
// the zero keystream after reset, all-zero and all-one keys and IVs, masking
// of the upper key and IV words, back-to-back restarts and a key change
// without restart. Random sessions follow: reconfigure while idle, usually restart,
// then a run of random bytes, under three mixes of source and sink stalls.
// ----------------------------------------------------------------------------
module trivium_keystream_cipher_top_tb;
    import tkc_pkg::*;

    localparam int WARMUP_ROUNDS = 1152;
    localparam int BITS_PER_ITEM = 8;
    localparam int CLK_PERIOD    = 12;
    localparam int DRAIN_CYCLES  = 4;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int PHASE_ITEMS   = 627;
    localparam int NUM_DIRECTED  = 30;

    typedef enum logic {
        ROW_CONFIG,
        ROW_BYTE
    } row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_IDX_W-1:0]     index;
        logic [CFG_DATA_W-1:0]    value;
        logic                     restart;
        logic [BYTE_W-1:0]        plain;
        logic                     fixed;
        logic [BYTE_W-1:0]        cipher;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [BYTE_W-1:0]     m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predicted cipher state and key material
    logic [LEN_A-1:0]      st_a = '0;
    logic [LEN_B-1:0]      st_b = '0;
    logic [LEN_C-1:0]      st_c = '0;
    logic [63:0]           key_lo = '0;
    logic [15:0]           key_hi = '0;
    logic [63:0]           iv_lo  = '0;
    logic [15:0]           iv_hi  = '0;

    logic [BYTE_W-1:0]     cipher_pending [$];
    stim_row_t             directed_rows [NUM_DIRECTED];
    int                    error_count      = 0;
    int                    sender_idle_pct  = 21;
    int                    sink_idle_pct    = 71;

    trivium_keystream_cipher_top #(
        .WARMUP_ROUNDS(WARMUP_ROUNDS),
        .BITS_PER_ITEM(BITS_PER_ITEM)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("trivium_keystream_cipher_top_tb: errors");
        $finish;
    end

    // one round of all three registers; returns the keystream bit
    function automatic logic clock_round();
        logic t1;
        logic t2;
        logic t3;
        logic z;
        t1 = st_a[65] ^ st_a[92];
        t2 = st_b[68] ^ st_b[83];
        t3 = st_c[65] ^ st_c[110];
        z  = t1 ^ t2 ^ t3;
        t1 = t1 ^ (st_a[90] & st_a[91]) ^ st_b[77];
        t2 = t2 ^ (st_b[81] & st_b[82]) ^ st_c[86];
        t3 = t3 ^ (st_c[108] & st_c[109]) ^ st_a[68];
        st_a = {st_a[LEN_A-2:0], t3};
        st_b = {st_b[LEN_B-2:0], t1};
        st_c = {st_c[LEN_C-2:0], t2};
        return z;
    endfunction

    function automatic logic [BYTE_W-1:0] encrypt_byte(input logic restart,
                                                       input logic [BYTE_W-1:0] plain);
        logic [63:0] ks;
        if (restart)
        begin
            st_a = '0;
            st_b = '0;
            st_c = '0;
            st_a[63:0]  = key_lo;
            st_a[79:64] = key_hi;
            st_b[63:0]  = iv_lo;
            st_b[79:64] = iv_hi;
            st_c[LEN_C-1 -: 3] = 3'b111;
            repeat (WARMUP_ROUNDS) void'(clock_round());
        end
        ks = '0;
        repeat (BITS_PER_ITEM) ks = {ks[62:0], clock_round()};
        return plain ^ ks[BYTE_W-1:0];
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] index,
                                          input logic [CFG_DATA_W-1:0] value);
        stim_row_t row;
        row = '0;
        row.kind  = ROW_CONFIG;
        row.index = index;
        row.value = value;
        return row;
    endfunction

    function automatic stim_row_t byte_row(input logic restart, input logic [BYTE_W-1:0] plain);
        stim_row_t row;
        row = '0;
        row.kind    = ROW_BYTE;
        row.restart = restart;
        row.plain   = plain;
        return row;
    endfunction

    function automatic stim_row_t fixed_row(input logic [BYTE_W-1:0] plain,
                                            input logic [BYTE_W-1:0] cipher);
        stim_row_t row;
        row = byte_row(1'b0, plain);
        row.fixed  = 1'b1;
        row.cipher = cipher;
        return row;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // all tasks below start and return at a falling edge
    task automatic send_byte(input logic restart, input logic [BYTE_W-1:0] plain,
                             input logic fixed, input logic [BYTE_W-1:0] cipher);
        logic [BYTE_W-1:0] predicted;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= restart;
        s_tdata  <= plain;
        do @(posedge clk); while (!s_tready);
        predicted = encrypt_byte(restart, plain);
        cipher_pending = {cipher_pending, (fixed ? cipher : predicted)};
        @(negedge clk);
    endtask

    // hold the source until every pending result has drained
    task automatic drain_stream();
        s_tvalid <= 1'b0;
        while (cipher_pending.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            CFG_KEY_LOW:  key_lo = value;
            CFG_KEY_HIGH: key_hi = value[KEY_HIGH_W-1:0];
            CFG_IV_LOW:   iv_lo  = value;
            CFG_IV_HIGH:  iv_hi  = value[KEY_HIGH_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // sessions: reconfigure while idle, usually restart, then a run of bytes
    task automatic run_sessions(input int n_items);
        int sent;
        int burst;
        logic restart;
        sent = 0;
        while (sent < n_items)
        begin
            drain_stream();
            for (int r = 0; r < 4; r++)
                if ($urandom_range(0, 3) != 0)
                    write_register(CFG_IDX_W'(r), rand_word());
            burst = $urandom_range(1, 80);
            for (int i = 0; i < burst; i++)
            begin
                restart = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 99) == 0);
                send_byte(restart, BYTE_W'($urandom), 1'b0, '0);
                sent++;
            end
        end
    endtask

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

    always @(posedge clk)
    begin
        logic [BYTE_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cipher_pending.size() == 0)
                report_mismatch($sformatf("result 0x%02h with none pending", m_tdata));
            else
            begin
                want = cipher_pending.pop_front();
                if (m_tdata !== want)
                    report_mismatch($sformatf("cipher_byte 0x%02h, want 0x%02h", m_tdata, want));
            end
        end
    end

    initial
    begin
        directed_rows = '{
            // zero state after reset: keystream is zero
            fixed_row(8'h00, 8'h00),
            fixed_row(8'hFF, 8'hFF),
            fixed_row(8'h5A, 8'h5A),
            byte_row(1'b1, 8'h00),
            byte_row(1'b0, 8'hFF),
            // all-one key and IV; upper bits of the high words must be dropped
            cfg_row(CFG_KEY_LOW,  64'hFFFF_FFFF_FFFF_FFFF),
            cfg_row(CFG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF),
            cfg_row(CFG_IV_LOW,   64'hFFFF_FFFF_FFFF_FFFF),
            cfg_row(CFG_IV_HIGH,  64'hFFFF_FFFF_FFFF_FFFF),
            byte_row(1'b1, 8'h00),
            byte_row(1'b0, 8'hFF),
            byte_row(1'b0, 8'h00),
            byte_row(1'b1, 8'hFF),
            byte_row(1'b1, 8'h00),
            // new key takes effect only at the next restart
            cfg_row(CFG_KEY_LOW,  64'h0123_4567_89AB_CDEF),
            cfg_row(CFG_KEY_HIGH, 64'h0000_0000_0000_BEEF),
            cfg_row(CFG_IV_LOW,   64'hFEDC_BA98_7654_3210),
            cfg_row(CFG_IV_HIGH,  64'hDEAD_0000_0000_1234),
            byte_row(1'b0, 8'hA5),
            byte_row(1'b1, 8'h3C),
            byte_row(1'b0, 8'hC3),
            byte_row(1'b0, 8'h80),
            byte_row(1'b0, 8'h01),
            cfg_row(CFG_KEY_LOW,  64'h0),
            cfg_row(CFG_KEY_HIGH, 64'h0),
            cfg_row(CFG_IV_LOW,   64'h0),
            cfg_row(CFG_IV_HIGH,  64'h0),
            byte_row(1'b1, 8'h00),
            byte_row(1'b0, 8'h00),
            byte_row(1'b0, 8'hFF)
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CONFIG)
            begin
                drain_stream();
                write_register(directed_rows[i].index, directed_rows[i].value);
            end
            else
                send_byte(directed_rows[i].restart, directed_rows[i].plain,
                          directed_rows[i].fixed, directed_rows[i].cipher);
        end

        run_sessions(PHASE_ITEMS);
        sender_idle_pct = 71;
        sink_idle_pct   = 21;
        run_sessions(PHASE_ITEMS);
        sender_idle_pct = 0;
        sink_idle_pct   = 0;
        run_sessions(PHASE_ITEMS);

        drain_stream();
        if (error_count == 0)
            $display("trivium_keystream_cipher_top_tb: clean");
        else
            $display("trivium_keystream_cipher_top_tb: errors");
        $finish;
    end

endmodule
